// ===== design/vfd_pkg.sv =====
// Package for the clock display refresh block: transfer types, codes,
// segment table and decimal digit split. No dependencies.
package vfd_pkg;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_TIME = 2'd1,
    ACT_DATE = 2'd2,
    ACT_NONE = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    CFG_DIM_SHIFT  = 2'd0,
    CFG_HOUR_MODE  = 2'd1,
    CFG_DATE_ORDER = 2'd2,
    CFG_UNUSED     = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    HM_24H    = 2'd0,
    HM_12H    = 2'd1,
    HM_12H_NZ = 2'd2,
    HM_12H_X  = 2'd3
  } hour_mode_e;

  typedef enum logic {
    ST_IDLE,
    ST_SHIFT
  } shf_state_e;

  localparam int unsigned REND_DIGITS = 6;
  localparam logic [7:0]  DOT_BIT     = 8'h01;
  localparam logic [4:0]  NOLZ_END    = 5'd22;
  localparam int unsigned CFG_W       = 3;

  typedef struct packed {
    logic [1:0] action;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
    logic [5:0] dot_mask;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } in_t;

  typedef struct packed {
    logic serial_bit;
    logic latch_now;
  } out_t;

  typedef struct packed {
    logic load;
    logic start;
    logic on;
  } shf_cmd_t;

  typedef struct packed {
    logic busy;
  } shf_status_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
  } digits_t;

  typedef logic [REND_DIGITS-1:0][7:0] pattern_t;

  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'hFC;
      4'd1:    s = 8'h60;
      4'd2:    s = 8'hDA;
      4'd3:    s = 8'hF2;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'hB6;
      4'd6:    s = 8'hBE;
      4'd7:    s = 8'hE0;
      4'd8:    s = 8'hFE;
      4'd9:    s = 8'hF6;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // reciprocal multiply, exact for values below 128
  function automatic digits_t split10(input logic [6:0] v);
    logic [14:0] p;
    digits_t     r;
    p      = 15'(v) * 15'd205;
    r.tens = p[14:11];
    r.ones = 4'(v - 7'(r.tens) * 7'd10);
    return r;
  endfunction

endpackage

// ===== design/vfd_clock_display_refresh.sv =====
// Top level of the clock display refresh block: configuration, dim counter,
// input control. Depends on vfd_pkg, vfd_render, vfd_shifter.
//
//   channel  direction  handshake                payload
//   in       input      in_valid_i / in_stall_o  in_data_i  (in_t)
//   out      output     out_valid_o / out_stall_i out_data_o (out_t)
//   cfg      input      cfg_we_i                 cfg_idx_i, cfg_data_i
//
// Render transfers update the store. A tick makes 8*NUM_DIGITS output
// transfers, one bit per cycle while the output is not stalled, from the
// rotating store register; the input stalls meanwhile.
// Output stalls hold the current bit. Reset clears store, counters, registers.
module vfd_clock_display_refresh import vfd_pkg::*; #(
  parameter int unsigned NUM_DIGITS = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_data_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  logic [2:0]  dim_shift_q;
  logic [1:0]  hour_mode_q;
  logic        date_order_q;
  logic [7:0]  dim_count_q, dim_count_d;
  logic [7:0]  dim_inc;
  logic        in_xfer;
  shf_cmd_t    cmd;
  shf_status_t status;
  pattern_t    pattern;

  assign in_stall_o = status.busy;
  assign in_xfer    = in_valid_i && !status.busy;

  always_comb begin
    cmd.load  = in_xfer && (in_data_i.action == ACT_TIME || in_data_i.action == ACT_DATE);
    cmd.start = in_xfer && (in_data_i.action == ACT_TICK);
    cmd.on    = (dim_count_q == 8'd0);
    dim_inc   = dim_count_q + 8'd1;
    dim_count_d = dim_count_q;
    if (cmd.start) begin
      dim_count_d = (dim_inc == (8'd1 << dim_shift_q)) ? 8'd0 : dim_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_shift_q  <= '0;
      hour_mode_q  <= '0;
      date_order_q <= 1'b0;
      dim_count_q  <= '0;
    end else begin
      dim_count_q <= dim_count_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DIM_SHIFT: begin
            dim_shift_q <= cfg_data_i[2:0];
            dim_count_q <= '0;
          end
          CFG_HOUR_MODE:  hour_mode_q  <= cfg_data_i[1:0];
          CFG_DATE_ORDER: date_order_q <= cfg_data_i[0];
          default: ;
        endcase
      end
    end
  end

  vfd_render u_render (
    .data_i      (in_data_i),
    .hour_mode_i (hour_mode_q),
    .date_order_i(date_order_q),
    .pattern_o   (pattern)
  );

  vfd_shifter #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_shifter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .pattern_i  (pattern),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .status_o   (status)
  );

`ifndef SYNTHESIS
  a_dim_hold_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.busy && !cfg_we_i) |=> $stable(dim_count_q))
    else $error("dim counter moved during refresh");
  a_dim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd.start) |-> (dim_count_q < (8'd1 << dim_shift_q) || dim_shift_q == 3'd0))
    else $error("dim counter beyond its period");
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |=> status.busy)
    else $error("tick did not start a refresh");
`endif

endmodule

// ===== design/vfd_render.sv =====
// Segment pattern builder for render time and render date transfers.
// Depends on vfd_pkg.
module vfd_render import vfd_pkg::*; (
  input  in_t        data_i,
  input  logic [1:0] hour_mode_i,
  input  logic       date_order_i,
  output pattern_t   pattern_o
);

  logic [4:0] hour_f;
  digits_t    sec_d, min_d, hr_d, yr_d, mid_d, top_d;
  logic [4:0] mid_v, top_v;
  pattern_t   time_p, date_p;

  always_comb begin
    hour_f = data_i.hour;
    if (hour_mode_i != HM_24H) begin
      if (data_i.hour > 5'd12) begin
        hour_f = data_i.hour - 5'd12;
      end else if (data_i.hour == 5'd0) begin
        hour_f = 5'd12;
      end
    end
    sec_d = split10({1'b0, data_i.second});
    min_d = split10({1'b0, data_i.minute});
    hr_d  = split10({2'b00, hour_f});
    time_p[0] = seg_of(sec_d.ones);
    time_p[1] = seg_of(sec_d.tens);
    time_p[2] = seg_of(min_d.ones);
    time_p[3] = seg_of(min_d.tens);
    time_p[4] = seg_of(hr_d.ones);
    time_p[5] = seg_of(hr_d.tens);
    for (int i = 0; i < REND_DIGITS; i++) begin
      time_p[i][0] = data_i.dot_mask[i];
    end
    // in 12-hour no-zero mode, blank the hour tens digit for hours 13 to 21, keep its dot
    if (hour_mode_i == HM_12H_NZ && data_i.hour > 5'd12 && data_i.hour < NOLZ_END) begin
      time_p[5] = time_p[5] & DOT_BIT;
    end

    mid_v = date_order_i ? {1'b0, data_i.month} : data_i.day;
    top_v = date_order_i ? data_i.day : {1'b0, data_i.month};
    yr_d  = split10(data_i.year);
    mid_d = split10({2'b00, mid_v});
    top_d = split10({2'b00, top_v});
    date_p[0] = seg_of(yr_d.ones);
    date_p[1] = seg_of(yr_d.tens);
    date_p[2] = seg_of(mid_d.ones) | DOT_BIT;
    date_p[3] = seg_of(mid_d.tens);
    date_p[4] = seg_of(top_d.ones) | DOT_BIT;
    date_p[5] = seg_of(top_d.tens);

    pattern_o = (data_i.action == ACT_DATE) ? date_p : time_p;
  end

endmodule

// ===== design/vfd_shifter.sv =====
// Display store as a rotating shift register, one bit out per transfer.
// Depends on vfd_pkg.
module vfd_shifter import vfd_pkg::*; #(
  parameter int unsigned NUM_DIGITS = 6
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  shf_cmd_t    cmd_i,
  input  pattern_t    pattern_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output out_t        out_data_o,
  output shf_status_t status_o
);

  localparam int unsigned BITS  = 8 * NUM_DIGITS;
  localparam int unsigned CNT_W = $clog2(BITS);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(BITS - 1);

  shf_state_e       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [BITS-1:0]  store_q, store_d;
  logic             on_q, on_d;
  logic [BITS-1:0]  load_v;
  logic             xfer, last;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      load_v[8*i +: 8] = (i < REND_DIGITS) ? pattern_i[i % REND_DIGITS] : 8'h00;
    end
  end

  assign xfer = (state_q == ST_SHIFT) && !out_stall_i;
  assign last = (cnt_q == LAST_BIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      store_q <= '0;
      on_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      store_q <= store_d;
      on_q    <= on_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    store_d = store_q;
    on_d    = on_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_i.load) begin
          store_d = load_v;
        end else if (cmd_i.start) begin
          on_d    = cmd_i.on;
          cnt_d   = '0;
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (xfer) begin
          // rotate so the store is intact after a full pass
          store_d = {store_q[0], store_q[BITS-1:1]};
          cnt_d   = cnt_q + CNT_W'(1);
          if (last) begin
            cnt_d   = '0;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o           = (state_q == ST_SHIFT);
  assign out_data_o.serial_bit = on_q & store_q[0];
  assign out_data_o.latch_now  = last;
  assign status_o.busy         = (state_q == ST_SHIFT);

`ifndef SYNTHESIS
  a_idle_cnt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (cnt_q == '0))
    else $error("bit counter not cleared while idle");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (xfer && last) |=> (state_q == ST_IDLE))
    else $error("refresh did not end after last bit");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |-> !(cmd_i.load || cmd_i.start))
    else $error("command issued during refresh");
  a_store_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT && out_stall_i) |=> $stable(store_q))
    else $error("store moved while output stalled");
`endif

endmodule
